// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication or plain property, checked on the rising clock edge outside reset.
`define PAFC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pafc assertion failed");
// Condition that must never be true outside reset.
`define PAFC_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("pafc forbidden condition seen");
`else
`define PAFC_ASSERT(lbl, clk, rstn, prop)
`define PAFC_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== design/pafc_pkg.sv =====
// Package for the probabilistic access-frequency counter: constants,
// control/status structs and the sequencer state type. No dependencies.
package pafc_pkg;

  localparam logic [63:0]  LEHMER_MULT   = 64'hda942042e4dd58b5;
  localparam logic [127:0] RNG_RESET     = 128'd1;
  localparam logic [7:0]   COUNT_MAX     = 8'd255;
  localparam logic [7:0]   CERTAIN_BELOW = 8'd32;
  localparam logic [5:0]   STEP_LAST     = 6'd63;

  // Request to the serial generator / remainder unit
  typedef struct packed {
    logic       start;
    logic [7:0] divisor;
  } pafc_ctl_t;

  // Status back from the unit
  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } pafc_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } pafc_state_t;

endpackage

// ===== design/pafc_if.sv =====
// Valid/ready channel interfaces for the hit input and the result output.
// Depends on nothing; payload fields are fixed 8-bit and 1-bit values.
interface pafc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] entry_count;
  logic [7:0] entry_stamp;
  logic [7:0] now_low;

  modport source (output valid, entry_count, entry_stamp, now_low, input ready);
  modport sink   (input valid, entry_count, entry_stamp, now_low, output ready);
endinterface

interface pafc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] new_count;
  logic [7:0] new_stamp;
  logic       bumped;

  modport source (output valid, new_count, new_stamp, bumped, input ready);
  modport sink   (input valid, new_count, new_stamp, bumped, output ready);
endinterface

// ===== design/probabilistic_access_frequency_counter_top.sv =====
// Approximate LFU counter top level with a Lehmer64 random source.
// Without a random draw an accepted hit goes straight to the decision and output load;
// with one, 64 serial multiply/remainder steps come first, then decision and output load.
// One item at a time; an output stall holds the finished item back from the output register.
// Next item is taken while a result waits.
// Reset (rst_n low, synchronous): generator state = 1, channels empty.
`include "assert_macros.svh"

module probabilistic_access_frequency_counter_top (
  input  logic              clk,
  input  logic              rst_n,
  pafc_in_if.sink           in_ch,
  pafc_out_if.source        out_ch
);

  pafc_pkg::pafc_state_t st_r, st_nxt;
  pafc_pkg::pafc_ctl_t   ctl;
  pafc_pkg::pafc_sts_t   sts;

  logic [7:0] count_r, stamp_r, now_r;
  logic       bump_r, bump_nxt;
  logic       out_valid_r, out_load;
  logic [7:0] out_count_r, out_stamp_r;
  logic       out_bump_r;
  logic       in_acc, skip, certain;

  pafc_lehmer u_lehmer (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sts   (sts)
  );

  assign in_ch.ready = (st_r == pafc_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign skip        = (in_ch.entry_count == pafc_pkg::COUNT_MAX) ||
                       (in_ch.entry_stamp == in_ch.now_low);
  assign certain     = in_ch.entry_count < pafc_pkg::CERTAIN_BELOW;

  // Sequencer next state and unit request
  always_comb begin
    st_nxt      = st_r;
    bump_nxt    = bump_r;
    ctl.start   = 1'b0;
    ctl.divisor = in_ch.entry_count;
    out_load    = 1'b0;
    case (st_r)
      pafc_pkg::ST_IDLE: begin
        if (in_acc) begin
          bump_nxt = !skip && certain;
          if (!skip && !certain) begin
            ctl.start = 1'b1;
            st_nxt    = pafc_pkg::ST_RUN;
          end else begin
            st_nxt = pafc_pkg::ST_FIN;
          end
        end
      end
      pafc_pkg::ST_RUN: begin
        if (sts.done) begin
          bump_nxt = sts.hit;
          st_nxt   = pafc_pkg::ST_FIN;
        end
      end
      pafc_pkg::ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          st_nxt   = pafc_pkg::ST_IDLE;
        end
      end
      default: st_nxt = pafc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pafc_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Hold the accepted hit and the decision
  always_ff @(posedge clk) begin
    bump_r <= bump_nxt;
    if (in_acc) begin
      count_r <= in_ch.entry_count;
      stamp_r <= in_ch.entry_stamp;
      now_r   <= in_ch.now_low;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= bump_r ? 8'(count_r + 8'd1) : count_r;
      out_stamp_r <= bump_r ? now_r : stamp_r;
      out_bump_r  <= bump_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.new_count = out_count_r;
  assign out_ch.new_stamp = out_stamp_r;
  assign out_ch.bumped    = out_bump_r;

  // Checks
  `PAFC_NEVER(a_ready_busy, clk, rst_n, in_ch.ready && sts.busy)
  `PAFC_ASSERT(a_done_in_run, clk, rst_n, sts.done |-> st_r == pafc_pkg::ST_RUN)
  `PAFC_ASSERT(a_start_idle, clk, rst_n, ctl.start |-> st_r == pafc_pkg::ST_IDLE)
  `PAFC_NEVER(a_bump_wrap, clk, rst_n, out_valid_r && out_bump_r && out_count_r == 8'd0)

endmodule

// ===== design/pafc_lehmer.sv =====
// Serial Lehmer64 advance plus LSB-first remainder of the low word.
// Depends on pafc_pkg (constants, control/status structs).
module pafc_lehmer (
  input  logic                clk,
  input  logic                rst_n,
  input  pafc_pkg::pafc_ctl_t ctl,
  output pafc_pkg::pafc_sts_t sts
);

  logic [127:0] state_r;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  lo_r, lo_nxt;
  logic [7:0]   rem_r, rem_nxt;
  logic [7:0]   pow_r, pow_nxt;
  logic [7:0]   div_r;
  logic [5:0]   step_r;
  logic         busy_r, done_r, hit_r;

  logic [127:0] addend, sum;
  logic         pbit;
  logic [8:0]   rsum, psum;

  // One multiplier bit per cycle; product bit i falls out of acc bit 0,
  // and feeds the remainder as bit_i * (2^i mod divisor).
  always_comb begin
    addend  = pafc_pkg::LEHMER_MULT[step_r] ? state_r : '0;
    sum     = acc_r + addend;
    pbit    = sum[0];
    acc_nxt = {1'b0, sum[127:1]};
    lo_nxt  = {pbit, lo_r[63:1]};
    rsum    = {1'b0, rem_r} + (pbit ? {1'b0, pow_r} : 9'd0);
    rem_nxt = (rsum >= {1'b0, div_r}) ? 8'(rsum - {1'b0, div_r}) : rsum[7:0];
    psum    = {pow_r, 1'b0};
    pow_nxt = (psum >= {1'b0, div_r}) ? 8'(psum - {1'b0, div_r}) : psum[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      state_r <= pafc_pkg::RNG_RESET;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        acc_r  <= '0;
        rem_r  <= '0;
        pow_r  <= 8'd1;
        div_r  <= ctl.divisor;
      end else if (busy_r) begin
        acc_r  <= acc_nxt;
        lo_r   <= lo_nxt;
        rem_r  <= rem_nxt;
        pow_r  <= pow_nxt;
        step_r <= 6'(step_r + 6'd1);
        if (step_r == pafc_pkg::STEP_LAST) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          hit_r   <= (rem_nxt == 8'd0);
          state_r <= {acc_nxt[63:0], lo_nxt};
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.hit  = hit_r;

endmodule
